// File: rtl/queue_pair_ring_doorbell_top_macros.svh
// assertion helpers for the queue pair ring doorbell block
// each macro expects signals named clock and reset in the using scope
`ifndef QUEUE_PAIR_RING_DOORBELL_TOP_MACROS_SVH
`define QUEUE_PAIR_RING_DOORBELL_TOP_MACROS_SVH

// same-cycle implication
`define QPRD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QPRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/qprd_pkg.sv
`default_nettype none

package qprd_pkg;

   localparam int QUEUE_DEPTH_DEF = 1024;
   localparam int TAG_WIDTH_DEF   = 32;

   localparam logic ACT_SUBMIT = 1'b0;
   localparam logic ACT_POLL   = 1'b1;

   localparam logic [7:0] CMD_SUBMIT   = 8'd0;
   localparam logic [7:0] CMD_COMPLETE = 8'd1;

   localparam logic CSR_DB_VERSION   = 1'b0;
   localparam logic CSR_QUEUE_NUMBER = 1'b1;

   localparam logic DB_VERSION_ONE = 1'b0;
   localparam logic DB_VERSION_TWO = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_HW_ERR  = 3'd1,
      ST_FULL    = 3'd2,
      ST_NO_CPL  = 3'd3,
      ST_BAD_IDX = 3'd4
   } status_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   function automatic logic [63:0] make_doorbell(
      input logic        version,
      input logic [15:0] qnum,
      input logic [7:0]  cmd,
      input logic [15:0] idx
   );
      logic [63:0] w;
      if (version == DB_VERSION_TWO) begin
         w = {16'd0, idx, 16'd0, cmd[3:0], 2'b00, qnum[9:0]};
      end else begin
         w = {16'd0, idx, 8'd0, cmd, qnum};
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/qprd_tag_ram.sv
`default_nettype none

module qprd_tag_ram #(
   parameter int DEPTH  = qprd_pkg::QUEUE_DEPTH_DEF,
   parameter int ADDR_W = 10,
   parameter int DATA_W = qprd_pkg::TAG_WIDTH_DEF
) (
   input  wire                        clock,
   input  wire qprd_pkg::ram_ctl_type ctl,
   input  wire [ADDR_W-1:0]           wr_addr,
   input  wire [DATA_W-1:0]           wr_data,
   input  wire [ADDR_W-1:0]           rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/queue_pair_ring_doorbell_top.sv
// host side of a submission/completion queue pair with a phase bit
// req channel: one transaction is a submit (action 0, carries request_tag) or a
//   poll (action 1, carries the head completion entry's phase and sq head)
// rsp channel: exactly one transaction per request: status, doorbell word and
//   the returned tag of a completed poll
// csr port: index 0 doorbell layout version, index 1 queue number; write only
// response: registered, presented in the cycle after the request is taken
// throughput: one transaction per cycle while req_stall is low; all pointer,
//   occupancy and doorbell work is done in the accepting cycle, the tag store
//   is one write port and one registered read port
// stall: while a response is held by rsp_stall, req_stall is raised so the
//   response register and tag read data stay put
// reset: tail, head and occupancy go to zero, expected phase to one,
//   doorbell version to two, queue number to zero; the tag store is not
//   cleared, entries are meaningful only after a submit wrote them
`default_nettype none

module queue_pair_ring_doorbell_top #(
   parameter int QUEUE_DEPTH = qprd_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_WIDTH   = qprd_pkg::TAG_WIDTH_DEF
) (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_action,
   input  wire  [31:0] req_request_tag,
   input  wire         req_entry_phase,
   input  wire  [15:0] req_entry_sq_head,
   input  wire         req_error_before,
   input  wire         req_error_after,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_doorbell_valid,
   output logic [63:0] rsp_doorbell_word,
   output logic [31:0] rsp_response_tag,

   input  wire         csr_write_enable,
   input  wire         csr_index,
   input  wire  [15:0] csr_write_data
);

   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OccW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
   localparam logic [OccW-1:0] FullOcc = OccW'(QUEUE_DEPTH);

   // configuration
   logic        db_version_ff;
   logic [15:0] qnum_ff;

   // ring state
   logic [IdxW-1:0] tail_ff, tail_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic            phase_ff, phase_in;
   logic [OccW-1:0] occ_ff, occ_in;

   // response register
   logic                  rsp_valid_ff;
   qprd_pkg::status_type  status_ff, status_in;
   logic                  db_valid_ff, db_valid_in;
   logic [63:0]           db_word_ff, db_word_in;
   logic                  tag_sel_ff;

   logic                  accept;
   logic                  submit_ok;
   logic                  poll_ok;
   logic                  ring_full;
   logic                  bad_index;
   logic [IdxW-1:0]       tail_next;
   logic [IdxW-1:0]       head_next;
   logic [TAG_WIDTH-1:0]  rd_tag;
   qprd_pkg::ram_ctl_type ram_ctl;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign ring_full = (occ_ff == FullOcc);
   assign bad_index = (17'(req_entry_sq_head) >= 17'(QUEUE_DEPTH));
   assign tail_next = (tail_ff == LastIdx) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;

   assign submit_ok = ~req_error_before & (req_action == qprd_pkg::ACT_SUBMIT) & ~ring_full;
   assign poll_ok   = ~req_error_before & (req_action == qprd_pkg::ACT_POLL)
                    & (req_entry_phase == phase_ff) & ~bad_index;

   always_comb begin
      tail_in     = tail_ff;
      head_in     = head_ff;
      phase_in    = phase_ff;
      occ_in      = occ_ff;
      status_in   = qprd_pkg::ST_OK;
      db_valid_in = 1'b0;
      db_word_in  = '0;
      if (req_error_before) begin
         status_in = qprd_pkg::ST_HW_ERR;
      end else if (req_action == qprd_pkg::ACT_SUBMIT) begin
         if (ring_full) begin
            status_in = qprd_pkg::ST_FULL;
         end else begin
            tail_in     = tail_next;
            occ_in      = occ_ff + 1'b1;
            db_valid_in = 1'b1;
            db_word_in  = qprd_pkg::make_doorbell(db_version_ff, qnum_ff,
                                                  qprd_pkg::CMD_SUBMIT, 16'(tail_next));
            status_in   = req_error_after ? qprd_pkg::ST_HW_ERR : qprd_pkg::ST_OK;
         end
      end else begin
         if (req_entry_phase != phase_ff) begin
            status_in = qprd_pkg::ST_NO_CPL;
         end else if (bad_index) begin
            status_in = qprd_pkg::ST_BAD_IDX;
         end else begin
            head_in     = head_next;
            // expected phase flips each time the head wraps
            phase_in    = (head_ff == LastIdx) ? ~phase_ff : phase_ff;
            // polling an empty ring is served but occupancy stays at zero
            occ_in      = (occ_ff != '0) ? occ_ff - 1'b1 : occ_ff;
            db_valid_in = 1'b1;
            db_word_in  = qprd_pkg::make_doorbell(db_version_ff, qnum_ff,
                                                  qprd_pkg::CMD_COMPLETE, 16'(head_next));
            status_in   = req_error_after ? qprd_pkg::ST_HW_ERR : qprd_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_version_ff <= qprd_pkg::DB_VERSION_TWO;
         qnum_ff       <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            qprd_pkg::CSR_DB_VERSION:   db_version_ff <= csr_write_data[0];
            qprd_pkg::CSR_QUEUE_NUMBER: qnum_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff  <= '0;
         head_ff  <= '0;
         phase_ff <= 1'b1;
         occ_ff   <= '0;
      end else if (accept) begin
         tail_ff  <= tail_in;
         head_ff  <= head_in;
         phase_ff <= phase_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         db_valid_ff <= db_valid_in;
         db_word_ff  <= db_word_in;
         tag_sel_ff  <= poll_ok;
      end
   end

   assign ram_ctl.wr_en = accept & submit_ok;
   assign ram_ctl.rd_en = accept & poll_ok;

   qprd_tag_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (IdxW),
      .DATA_W (TAG_WIDTH)
   ) u_tag_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (tail_ff),
      .wr_data (TAG_WIDTH'(req_request_tag)),
      .rd_addr (head_ff),
      .rd_data (rd_tag)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_doorbell_valid = db_valid_ff;
   assign rsp_doorbell_word  = db_word_ff;
   assign rsp_response_tag   = tag_sel_ff ? 32'(rd_tag) : 32'd0;

endmodule

`default_nettype wire

// File: rtl/qprd_checker.sv
`default_nettype none

`include "queue_pair_ring_doorbell_top_macros.svh"

module qprd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [2:0]  rsp_status,
   input wire        rsp_doorbell_valid,
   input wire [63:0] rsp_doorbell_word,
   input wire [31:0] rsp_response_tag
);

   logic        refused;
   logic        idle_db;
   logic        tag_back;
   logic        rsp_busy;
   logic [99:0] rsp_payload;

   assign refused     = rsp_valid && (rsp_status == qprd_pkg::ST_FULL ||
                                      rsp_status == qprd_pkg::ST_NO_CPL ||
                                      rsp_status == qprd_pkg::ST_BAD_IDX);
   assign idle_db     = rsp_valid && !rsp_doorbell_valid;
   assign tag_back    = rsp_valid && (rsp_response_tag != 32'd0);
   assign rsp_busy    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_status, rsp_doorbell_valid, rsp_doorbell_word, rsp_response_tag};

   // a refused transaction never rings a doorbell
   `QPRD_ASSERT_NOW(a_refused_no_db, refused, !rsp_doorbell_valid, "refusal rang a doorbell")

   // the doorbell word is zero whenever no doorbell is written
   `QPRD_ASSERT_NOW(a_db_word_zero, idle_db, rsp_doorbell_word == 64'd0, "stray doorbell word")

   // a returned tag comes only with a completion doorbell
   `QPRD_ASSERT_NOW(a_tag_needs_db, tag_back, rsp_doorbell_valid, "tag without doorbell")

   // a stalled response holds
   `QPRD_ASSERT_NEXT(a_rsp_hold, rsp_busy, rsp_valid && $stable(rsp_payload), "response not held")

endmodule

bind queue_pair_ring_doorbell_top qprd_checker u_qprd_checker (.*);

`default_nettype wire

// File: verif/queue_pair_ring_doorbell_top_test.sv
`timescale 1ns / 1ps

module queue_pair_ring_doorbell_top_test;

   localparam int RING_SLOTS  = qprd_pkg::QUEUE_DEPTH_DEF;
   localparam int SLOT_W      = $clog2(RING_SLOTS);
   localparam int CYCLE_LIMIT = 400000;
   localparam int MIXED_ITEMS = 12;

   typedef struct packed {
      logic        action;
      logic [31:0] tag;
      logic        phase;
      logic [15:0] sq_head;
      logic        err_before;
      logic        err_after;
   } ring_req_type;

   typedef struct packed {
      qprd_pkg::status_type status;
      logic                 db_valid;
      logic [63:0]          db_word;
      logic [31:0]          resp_tag;
   } ring_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_stall;
   logic        req_action = 1'b0;
   logic [31:0] req_request_tag = '0;
   logic        req_entry_phase = 1'b0;
   logic [15:0] req_entry_sq_head = '0;
   logic        req_error_before = 1'b0;
   logic        req_error_after = 1'b0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire  [2:0]  rsp_status;
   wire         rsp_doorbell_valid;
   wire  [63:0] rsp_doorbell_word;
   wire  [31:0] rsp_response_tag;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_write_data = '0;

   // shadow of the ring state and registers
   logic              db_layout = qprd_pkg::DB_VERSION_TWO;
   logic [15:0]       qp_number = '0;
   logic [SLOT_W-1:0] sq_tail = '0;
   logic [SLOT_W-1:0] cq_head = '0;
   logic              cq_phase = 1'b1;
   int unsigned       ring_fill = 0;
   logic [31:0]       tag_mem [RING_SLOTS];
   bit                tag_written [RING_SLOTS];

   ring_rsp_type ring_results_due[$];
   int           errors = 0;
   int           cycle_count = 0;
   bit           quiet_stretch = 1'b0;

   queue_pair_ring_doorbell_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_request_tag    (req_request_tag),
      .req_entry_phase    (req_entry_phase),
      .req_entry_sq_head  (req_entry_sq_head),
      .req_error_before   (req_error_before),
      .req_error_after    (req_error_after),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_doorbell_valid (rsp_doorbell_valid),
      .rsp_doorbell_word  (rsp_doorbell_word),
      .rsp_response_tag   (rsp_response_tag),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_stretch && ($urandom_range(0, 99) < 23);
      end
   end

   function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] i);
      return (i == RING_SLOTS - 1) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [63:0] format_doorbell(logic [7:0] cmd, logic [15:0] idx);
      logic [63:0] w;
      w = '0;
      w[47:32] = idx;
      if (db_layout == qprd_pkg::DB_VERSION_TWO) begin
         w[9:0]   = qp_number[9:0];
         w[15:12] = cmd[3:0];
      end else begin
         w[15:0]  = qp_number;
         w[23:16] = cmd;
      end
      return w;
   endfunction

   // advances the shadow ring by one transaction and returns its response
   function automatic ring_rsp_type apply_ring_op(ring_req_type it);
      ring_rsp_type      r;
      logic [SLOT_W-1:0] nxt;
      r.status   = qprd_pkg::ST_OK;
      r.db_valid = 1'b0;
      r.db_word  = '0;
      r.resp_tag = '0;
      if (it.err_before) begin
         r.status = qprd_pkg::ST_HW_ERR;
      end else if (it.action == qprd_pkg::ACT_SUBMIT) begin
         if (ring_fill >= RING_SLOTS) begin
            r.status = qprd_pkg::ST_FULL;
         end else begin
            tag_mem[sq_tail]     = it.tag;
            tag_written[sq_tail] = 1'b1;
            nxt        = next_slot(sq_tail);
            r.db_valid = 1'b1;
            r.db_word  = format_doorbell(qprd_pkg::CMD_SUBMIT, 16'(nxt));
            sq_tail    = nxt;
            ring_fill++;
            if (it.err_after) r.status = qprd_pkg::ST_HW_ERR;
         end
      end else begin
         if (it.phase != cq_phase) begin
            r.status = qprd_pkg::ST_NO_CPL;
         end else if (it.sq_head >= RING_SLOTS) begin
            r.status = qprd_pkg::ST_BAD_IDX;
         end else begin
            r.resp_tag = tag_mem[cq_head];
            if (cq_head == RING_SLOTS - 1) cq_phase = ~cq_phase;
            nxt        = next_slot(cq_head);
            r.db_valid = 1'b1;
            r.db_word  = format_doorbell(qprd_pkg::CMD_COMPLETE, 16'(nxt));
            cq_head    = nxt;
            if (ring_fill > 0) ring_fill--;
            if (it.err_after) r.status = qprd_pkg::ST_HW_ERR;
         end
      end
      return r;
   endfunction

   function automatic ring_req_type mk_req(logic action, logic [31:0] tag, logic phase,
                                           logic [15:0] sq_head, logic eb, logic ea);
      ring_req_type it;
      it.action     = action;
      it.tag        = tag;
      it.phase      = phase;
      it.sq_head    = sq_head;
      it.err_before = eb;
      it.err_after  = ea;
      return it;
   endfunction

   function automatic ring_req_type random_req();
      ring_req_type it;
      it.action     = ($urandom_range(0, 99) < 50) ? qprd_pkg::ACT_POLL : qprd_pkg::ACT_SUBMIT;
      it.tag        = $urandom;
      it.phase      = ($urandom_range(0, 99) < 80) ? cq_phase : ~cq_phase;
      it.sq_head    = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, RING_SLOTS - 1))
                                                   : 16'($urandom_range(RING_SLOTS, 65535));
      it.err_before = $urandom_range(0, 99) < 8;
      it.err_after  = $urandom_range(0, 99) < 10;
      return it;
   endfunction

   // called at a rising edge, returns at the edge where the transaction is taken
   task automatic send_item(input ring_req_type it);
      ring_rsp_type r;
      bit           took;
      // a served poll must never read a slot no submit has written
      if (!it.err_before && it.action == qprd_pkg::ACT_POLL && it.phase == cq_phase &&
          it.sq_head < RING_SLOTS && !tag_written[cq_head]) begin
         it.phase = ~it.phase;
      end
      if (!quiet_stretch) begin
         while ($urandom_range(0, 99) < 23) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_action        <= it.action;
      req_request_tag   <= it.tag;
      req_entry_phase   <= it.phase;
      req_entry_sq_head <= it.sq_head;
      req_error_before  <= it.err_before;
      req_error_after   <= it.err_after;
      r = apply_ring_op(it);
      do begin
         @(negedge clock);
         took = req_valid && !req_stall;
         @(posedge clock);
      end while (!took);
      ring_results_due.push_back(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (ring_results_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_index        <= idx;
      csr_write_data   <= data;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == qprd_pkg::CSR_DB_VERSION) begin
         db_layout = data[0];
      end else begin
         qp_number = data;
      end
      @(posedge clock);
   endtask

   // response is checked at the falling edge, taken at the next rising edge
   always @(negedge clock) begin
      ring_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ring_results_due.size() == 0) begin
            $display("%0t: response transaction with nothing expected", $time);
            errors++;
         end else begin
            want = ring_results_due.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               errors++;
            end
            if (rsp_doorbell_valid !== want.db_valid) begin
               $display("%0t: doorbell_valid expected %0b actual %0b", $time,
                        want.db_valid, rsp_doorbell_valid);
               errors++;
            end
            if (rsp_doorbell_word !== want.db_word) begin
               $display("%0t: doorbell_word expected %h actual %h", $time,
                        want.db_word, rsp_doorbell_word);
               errors++;
            end
            if (rsp_response_tag !== want.resp_tag) begin
               $display("%0t: response_tag expected %h actual %h", $time,
                        want.resp_tag, rsp_response_tag);
               errors++;
            end
         end
      end
   end

   task automatic test_reset_values();
      // reset layout is version two, queue number zero
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, 1'b0, 16'd0, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, 1'b1, 16'd0, 1'b1, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, 1'b1, 16'd1024, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, 1'b1, 16'hffff, 1'b0, 1'b1));
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, 32'h0, 1'b0, 16'd0, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, 32'hffff_ffff, 1'b1, 16'hffff, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, 32'h5a5a_a5a5, 1'b0, 16'd0, 1'b0, 1'b1));
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, 32'h1234_5678, 1'b0, 16'd0, 1'b1, 1'b1));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'hffff_ffff, 1'b1, 16'd0, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, 1'b1, 16'd1023, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, 1'b1, 16'd512, 1'b0, 1'b1));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, 1'b0, 16'd3, 1'b0, 1'b0));
      drain_results();
      write_csr(qprd_pkg::CSR_DB_VERSION, 16'(qprd_pkg::DB_VERSION_ONE));
      write_csr(qprd_pkg::CSR_QUEUE_NUMBER, 16'hffff);
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, 32'ha5a5_0001, 1'b0, 16'd0, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, cq_phase, 16'd7, 1'b0, 1'b0));
      drain_results();
      write_csr(qprd_pkg::CSR_DB_VERSION, 16'(qprd_pkg::DB_VERSION_TWO));
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, 32'ha5a5_0002, 1'b0, 16'd0, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, cq_phase, 16'd9, 1'b0, 1'b0));
      drain_results();
      write_csr(qprd_pkg::CSR_DB_VERSION, 16'(qprd_pkg::DB_VERSION_ONE));
      write_csr(qprd_pkg::CSR_QUEUE_NUMBER, 16'h0000);
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, 32'ha5a5_0003, 1'b0, 16'd0, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, cq_phase, 16'd0, 1'b0, 1'b0));
   endtask

   task automatic test_ring_full();
      drain_results();
      write_csr(qprd_pkg::CSR_DB_VERSION, 16'($urandom_range(0, 1)));
      write_csr(qprd_pkg::CSR_QUEUE_NUMBER, 16'($urandom));
      // back to back fill with no idling on either side
      quiet_stretch = 1'b1;
      while (ring_fill < RING_SLOTS) begin
         send_item(mk_req(qprd_pkg::ACT_SUBMIT, $urandom, 1'($urandom_range(0, 1)),
                          16'($urandom), 1'b0, $urandom_range(0, 99) < 10));
      end
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, $urandom, 1'b0, 16'd0, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, $urandom, 1'b0, 16'd0, 1'b0, 1'b1));
      send_item(mk_req(qprd_pkg::ACT_SUBMIT, $urandom, 1'b0, 16'd0, 1'b1, 1'b0));
      quiet_stretch = 1'b0;
      // drain through the head wrap so the phase flips
      while (ring_fill > 0) begin
         send_item(mk_req(qprd_pkg::ACT_POLL, $urandom, cq_phase,
                          16'($urandom_range(0, RING_SLOTS - 1)),
                          $urandom_range(0, 99) < 2, $urandom_range(0, 99) < 10));
      end
      // polls on the empty ring are still served
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, cq_phase, 16'd1023, 1'b0, 1'b0));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, cq_phase, 16'd0, 1'b0, 1'b1));
      send_item(mk_req(qprd_pkg::ACT_POLL, 32'h0, cq_phase, 16'd77, 1'b0, 1'b0));
   endtask

   task automatic test_mixed_traffic();
      logic        layouts [4];
      logic [15:0] numbers [4];
      layouts = '{qprd_pkg::DB_VERSION_ONE, qprd_pkg::DB_VERSION_TWO,
                  qprd_pkg::DB_VERSION_ONE, logic'($urandom_range(0, 1))};
      numbers = '{16'h0000, 16'hffff, 16'hffff, 16'($urandom)};
      for (int s = 0; s < 4; s++) begin
         drain_results();
         write_csr(qprd_pkg::CSR_DB_VERSION, 16'(layouts[s]));
         write_csr(qprd_pkg::CSR_QUEUE_NUMBER, numbers[s]);
         for (int i = 0; i < MIXED_ITEMS; i++) begin
            if (i == MIXED_ITEMS / 2) drain_results();
            send_item(random_req());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_ring_full();
      test_mixed_traffic();
      drain_results();
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
